@@ rtl/core/dns_pkg.sv @@
package dns_pkg;

	localparam int unsigned SIGMOID_SEGMENTS_DEF = 256;
	localparam int unsigned ACC_W = 48;
	localparam int unsigned PROD_W = 32;
	localparam int unsigned CLAMP_W = 28;
	localparam int unsigned OUT_W = 13;
	localparam int unsigned FRAC_W = 8;
	localparam int unsigned QUEUE_DEPTH = 8;
	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam longint unsigned Q30_ONE = 64'h4000_0000;

	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] count;
	} fifo_stat_t;

	// Quotient by shift and subtract; only used while building constants.
	function automatic longint unsigned const_udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		int              b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Entry k is round(4096 * sigmoid(-8 + 16*k/segs)); evaluated at elaboration only.
	function automatic logic [OUT_W-1:0] sigmoid_entry(input int unsigned k,
		input int unsigned segs);
		longint unsigned s;
		longint unsigned kk;
		longint unsigned a;
		longint unsigned dv;
		longint unsigned term;
		longint unsigned v;
		longint unsigned den;
		longint unsigned num;
		longint          acc;
		logic            neg;
		int              n;
		int              i;
		s = 64'(segs);
		kk = 64'(k);
		neg = (16 * kk) < (8 * s);
		a = neg ? (8 * s - 16 * kk) : (16 * kk - 8 * s);
		dv = 16 * s;
		acc = longint'(Q30_ONE);
		term = Q30_ONE;
		for (n = 1; n < 40; n++) begin
			term = const_udiv(term * a, dv * 64'(n));
			if (n[0]) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		v = (acc < 0) ? 64'd0 : 64'(acc);
		for (i = 0; i < 4; i++) begin
			v = (v * v + (Q30_ONE >> 1)) >> 30;
		end
		den = Q30_ONE + v;
		num = neg ? (64'd4096 * v) : (64'd4096 << 30);
		return OUT_W'(const_udiv(2 * num + den, 2 * den));
	endfunction

endpackage

@@ rtl/core/dns_fifo.sv @@
module dns_fifo #(
	parameter int unsigned WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                pop,
	output logic [WIDTH-1:0]    rdata,
	output dns_pkg::fifo_stat_t stat
);

	logic [WIDTH-1:0]          mem [dns_pkg::QUEUE_DEPTH];
	logic [dns_pkg::PTR_W-1:0] wr_q;
	logic [dns_pkg::PTR_W-1:0] rd_q;
	logic [dns_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata = mem[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

endmodule

@@ rtl/core/dns_front.sv @@
module dns_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic signed [15:0]                  activation,
	input  logic signed [15:0]                  weight,
	input  logic                                last_term,
	output logic                                full,
	input  dns_pkg::fifo_stat_t                 q_stat,
	output logic                                q_push,
	output logic        [dns_pkg::ACC_W-1:0]    q_sum
);

	logic signed [dns_pkg::PROD_W-1:0] prod_s1;
	logic                              last_s1;
	logic                              valid_s1;
	logic        [dns_pkg::ACC_W-1:0]  acc_q;
	logic        [dns_pkg::ACC_W-1:0]  sum_next;
	logic        [dns_pkg::CNT_W:0]    need;
	logic                              take;

	// A last term still in the multiplier already owns a slot in the queue.
	assign need = {1'b0, q_stat.count} + (dns_pkg::CNT_W + 1)'(valid_s1 & last_s1);
	assign full = (need >= (dns_pkg::CNT_W + 1)'(dns_pkg::QUEUE_DEPTH));
	assign take = push && !full;

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= activation * weight;
			last_s1 <= last_term;
		end
	end

	assign sum_next = acc_q + dns_pkg::ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			valid_s1 <= take;
			if (valid_s1) begin
				acc_q <= last_s1 ? '0 : sum_next;
			end
		end
	end

	assign q_push = valid_s1 && last_s1;
	assign q_sum = sum_next;

endmodule

@@ rtl/core/dns_back.sv @@
module dns_back #(
	parameter int unsigned SIGMOID_SEGMENTS = dns_pkg::SIGMOID_SEGMENTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dns_pkg::fifo_stat_t              q_stat,
	input  logic        [dns_pkg::ACC_W-1:0] q_sum,
	output logic                             q_pop,
	input  dns_pkg::fifo_stat_t              o_stat,
	output logic                             o_push,
	output logic        [dns_pkg::OUT_W-1:0] o_value
);

	localparam int unsigned IDX_W = $clog2(SIGMOID_SEGMENTS);
	localparam int unsigned SEG_W = $clog2(SIGMOID_SEGMENTS + 1);
	localparam int unsigned P_W = dns_pkg::CLAMP_W + SEG_W;
	localparam int unsigned M_W = dns_pkg::OUT_W + dns_pkg::FRAC_W + 1;
	localparam int unsigned ACC_HI = dns_pkg::ACC_W - dns_pkg::CLAMP_W + 1;

	logic [dns_pkg::OUT_W-1:0] sig_tab [SIGMOID_SEGMENTS+1];

	for (genvar k = 0; k <= SIGMOID_SEGMENTS; k++) begin : g_tab
		localparam logic [dns_pkg::OUT_W-1:0] Entry =
			dns_pkg::sigmoid_entry(k, SIGMOID_SEGMENTS);
		assign sig_tab[k] = Entry;
	end

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic [dns_pkg::CLAMP_W-1:0]   u_s1;
	logic [IDX_W-1:0]              idx_s2;
	logic [dns_pkg::FRAC_W-1:0]    frac_s2, frac_s3;
	logic [dns_pkg::OUT_W-1:0]     t0_s3, t1_s3;
	logic [M_W-1:0]                m0_s4, m1_s4;
	logic [dns_pkg::CLAMP_W-1:0]   u_next;
	logic [P_W-1:0]                p;
	logic [SEG_W-1:0]              addr0, addr1;
	logic [M_W+1:0]                mix;
	logic [dns_pkg::CNT_W:0]       occ;
	logic [ACC_HI-1:0]             top_bits;

	assign occ = {1'b0, o_stat.count} + (dns_pkg::CNT_W + 1)'(v_s1) +
		(dns_pkg::CNT_W + 1)'(v_s2) + (dns_pkg::CNT_W + 1)'(v_s3) +
		(dns_pkg::CNT_W + 1)'(v_s4);
	assign q_pop = !q_stat.empty && (occ < (dns_pkg::CNT_W + 1)'(dns_pkg::QUEUE_DEPTH));

	// The sum lies in [-8,8) exactly when its bits from 27 upward are all equal.
	assign top_bits = q_sum[dns_pkg::ACC_W-1 -: ACC_HI];
	always_comb begin
		if (top_bits == '0 || top_bits == '1) begin
			u_next = {~q_sum[dns_pkg::CLAMP_W-1], q_sum[dns_pkg::CLAMP_W-2:0]};
		end else if (q_sum[dns_pkg::ACC_W-1]) begin
			u_next = '0;
		end else begin
			u_next = '1;
		end
	end

	assign p = P_W'(u_s1) * P_W'(SIGMOID_SEGMENTS);
	assign addr0 = SEG_W'(idx_s2);
	assign addr1 = SEG_W'(idx_s2) + 1'b1;
	assign mix = (M_W + 2)'(m0_s4) + (M_W + 2)'(m1_s4) + (M_W + 2)'(128);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			u_s1 <= u_next;
		end
		if (v_s1) begin
			idx_s2 <= p[dns_pkg::CLAMP_W +: IDX_W];
			frac_s2 <= p[dns_pkg::CLAMP_W-1 -: dns_pkg::FRAC_W];
		end
		if (v_s2) begin
			t0_s3 <= sig_tab[addr0];
			t1_s3 <= sig_tab[addr1];
			frac_s3 <= frac_s2;
		end
		if (v_s3) begin
			m0_s4 <= M_W'(t0_s3) * M_W'(9'd256 - {1'b0, frac_s3});
			m1_s4 <= M_W'(t1_s3) * M_W'(frac_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign o_push = v_s4;
	assign o_value = mix[dns_pkg::FRAC_W +: dns_pkg::OUT_W];

endmodule

@@ rtl/core/dense_neuron_sigmoid_unit.sv @@
// Dense-layer neuron with sigmoid activation.
// Input queue side: drive activation, weight and last_term with push; an item
// is taken at a clock edge where push is high and full is low. Each item is
// one multiply-accumulate; last_term closes the neuron and clears the sum.
// Result queue side: while empty is low, neuron_value shows the oldest
// result (unsigned Q1.12, 0 to 4096); pop with empty low takes it.
// Throughput is one item per cycle while full is low, set by the single
// multiplier and the 48-bit accumulator. A finished sum passes the
// multiply-accumulate front and the sum queue, then the sigmoid back end
// (clamp, table index, table read, interpolation) and the output queue.
// Eight-entry queues sit between front and back and at the output. When the
// receiver stops popping, the output queue fills, the back end stops draining
// finished sums, and full rises once those sums could no longer be stored.
// Reset clears the accumulator and both queues; the sigmoid table is fixed.
module dense_neuron_sigmoid_unit #(
	parameter int unsigned SIGMOID_SEGMENTS = dns_pkg::SIGMOID_SEGMENTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic signed [15:0]               activation,
	input  logic signed [15:0]               weight,
	input  logic                             last_term,
	input  logic                             pop,
	output logic                             empty,
	output logic        [dns_pkg::OUT_W-1:0] neuron_value
);

	dns_pkg::fifo_stat_t             sq_stat;
	dns_pkg::fifo_stat_t             oq_stat;
	logic                            sq_push;
	logic                            sq_pop;
	logic [dns_pkg::ACC_W-1:0]       sq_wdata;
	logic [dns_pkg::ACC_W-1:0]       sq_rdata;
	logic                            oq_push;
	logic [dns_pkg::OUT_W-1:0]       oq_wdata;
	logic                            oq_pop;

	dns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.activation (activation),
		.weight     (weight),
		.last_term  (last_term),
		.full       (full),
		.q_stat     (sq_stat),
		.q_push     (sq_push),
		.q_sum      (sq_wdata)
	);

	dns_fifo #(
		.WIDTH (dns_pkg::ACC_W)
	) u_sum_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (sq_push),
		.wdata  (sq_wdata),
		.pop    (sq_pop),
		.rdata  (sq_rdata),
		.stat   (sq_stat)
	);

	dns_back #(
		.SIGMOID_SEGMENTS (SIGMOID_SEGMENTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (sq_stat),
		.q_sum   (sq_rdata),
		.q_pop   (sq_pop),
		.o_stat  (oq_stat),
		.o_push  (oq_push),
		.o_value (oq_wdata)
	);

	assign oq_pop = pop && !oq_stat.empty;

	dns_fifo #(
		.WIDTH (dns_pkg::OUT_W)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wdata  (oq_wdata),
		.pop    (oq_pop),
		.rdata  (neuron_value),
		.stat   (oq_stat)
	);

	assign empty = oq_stat.empty;

endmodule

@@ rtl/core/dns_checker.sv @@
module dns_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             push,
	input logic                             full,
	input logic                             pop,
	input logic                             empty,
	input logic        [dns_pkg::OUT_W-1:0] neuron_value
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("queues not empty during reset");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> neuron_value <= 13'd4096)
		else $error("neuron value above 1.0");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(neuron_value))
		else $error("waiting result changed or vanished");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty)
		else $error("result present right after reset");

endmodule

bind dense_neuron_sigmoid_unit dns_checker u_dns_checker (.*);

@@ tb/sv/tb_dense_neuron_sigmoid_unit.sv @@
`timescale 1ns / 100ps

module tb_dense_neuron_sigmoid_unit;

	localparam int unsigned SEGMENTS = dns_pkg::SIGMOID_SEGMENTS_DEF;
	localparam int unsigned OUT_W = dns_pkg::OUT_W;
	localparam longint unsigned Q30 = 64'h4000_0000;
	localparam longint CLAMP_EDGE = 64'sd134217728;
	localparam int unsigned LARGE_TERMS = 64;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic signed [15:0]       activation;
	logic signed [15:0]       weight;
	logic                     last_term;
	logic                     pop;
	logic                     empty;
	logic        [OUT_W-1:0]  neuron_value;

	logic        [OUT_W-1:0]  sigmoid_lut [0:SEGMENTS];
	logic signed [47:0]       mac_sum;
	logic        [OUT_W-1:0]  expected_neuron_values [$];
	logic        [OUT_W-1:0]  wanted_value;
	int                       errors;
	bit                       send_idle;
	bit                       recv_idle;
	int                       hold_request;

	dense_neuron_sigmoid_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.activation   (activation),
		.weight       (weight),
		.last_term    (last_term),
		.pop          (pop),
		.empty        (empty),
		.neuron_value (neuron_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned exp_neg_fixed(input longint unsigned a);
		longint unsigned divisor;
		longint unsigned term;
		longint unsigned v;
		longint          series;
		int              n;
		divisor = 16 * longint'(SEGMENTS);
		series = longint'(Q30);
		term = Q30;
		for (n = 1; n < 40 && term != 0; n++) begin
			term = (term * a) / (divisor * longint'(n));
			if ((n % 2) == 1) begin
				series = series - longint'(term);
			end else begin
				series = series + longint'(term);
			end
		end
		if (series < 0) begin
			v = 0;
		end else begin
			v = longint'(series);
		end
		for (n = 0; n < 4; n++) begin
			v = (v * v + (Q30 >> 1)) >> 30;
		end
		return v;
	endfunction

	task automatic build_sigmoid_lut();
		longint unsigned k;
		longint unsigned s;
		longint unsigned a;
		longint unsigned e;
		longint unsigned num;
		longint unsigned den;
		bit              negative;
		s = SEGMENTS;
		for (k = 0; k <= s; k++) begin
			negative = (16 * k) < (8 * s);
			a = negative ? (8 * s - 16 * k) : (16 * k - 8 * s);
			e = exp_neg_fixed(a);
			den = Q30 + e;
			num = negative ? (64'd4096 * e) : (64'd4096 << 30);
			sigmoid_lut[k] = OUT_W'((2 * num + den) / (2 * den));
		end
	endtask

	function automatic logic [OUT_W-1:0] sigmoid_q412(input logic signed [47:0] sum);
		longint          s;
		longint unsigned u;
		longint unsigned p;
		longint unsigned idx;
		longint unsigned f;
		longint unsigned mix;
		s = sum;
		if (s < -CLAMP_EDGE) begin
			u = 0;
		end else if (s >= CLAMP_EDGE) begin
			u = 2 * CLAMP_EDGE - 1;
		end else begin
			u = s + CLAMP_EDGE;
		end
		p = u * SEGMENTS;
		idx = p >> 28;
		if (idx >= SEGMENTS) begin
			idx = SEGMENTS - 1;
		end
		f = (p >> 20) & 64'hFF;
		mix = 64'(sigmoid_lut[idx]) * (256 - f) + 64'(sigmoid_lut[idx + 1]) * f + 128;
		return OUT_W'(mix >> 8);
	endfunction

	function automatic void mac_predict(input logic signed [15:0] a,
		input logic signed [15:0] w, input logic last);
		logic signed [31:0] product;
		product = a * w;
		mac_sum = mac_sum + {{16{product[31]}}, product};
		if (last) begin
			expected_neuron_values.push_back(sigmoid_q412(mac_sum));
			mac_sum = '0;
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(input logic signed [15:0] a, input logic signed [15:0] w,
		input logic last);
		int gap;
		gap = send_idle ? $urandom_range(0, 19) : 0;
		repeat (gap) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		activation <= a;
		weight <= w;
		last_term <= last;
		do @(posedge clk); while (full);
		mac_predict(a, w, last);
		@(negedge clk);
	endtask

	task automatic drain_results();
		int n;
		n = 0;
		push <= 1'b0;
		while (expected_neuron_values.size() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(negedge clk);
	endtask

	function automatic logic signed [15:0] random_q412(input bit full_range);
		int v;
		if (full_range) begin
			v = $urandom_range(0, 65535);
		end else begin
			v = $urandom_range(0, 8191) - 4096;
		end
		return 16'(v);
	endfunction

	task automatic test_field_extremes();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		send_item(16'sd0, 16'sd0, 1'b1);
		send_item(-16'sd32768, -16'sd32768, 1'b1);
		send_item(-16'sd32768, 16'sd32767, 1'b1);
		send_item(16'sd32767, 16'sd32767, 1'b1);
		send_item(16'sd32767, -16'sd1, 1'b1);
		send_item(-16'sd1, -16'sd1, 1'b1);
		send_item(16'sd1, 16'sd1, 1'b0);
		send_item(-16'sd1, 16'sd1, 1'b1);
		send_item(16'sd4096, 16'sd4096, 1'b0);
		send_item(-16'sd4096, 16'sd2048, 1'b0);
		send_item(16'sd1234, -16'sd3000, 1'b1);
		drain_results();
	endtask

	// Sums right at the edges of the [-8, 8) window and single steps of the table and of its interpolation.
	task automatic test_clamp_edges();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_item(16'sd8192, 16'sd16384, 1'b1);
		send_item(16'sd8192, 16'sd16384, 1'b0);
		send_item(-16'sd1, 16'sd1, 1'b1);
		send_item(-16'sd8192, 16'sd16384, 1'b1);
		send_item(-16'sd8192, 16'sd16384, 1'b0);
		send_item(-16'sd1, 16'sd1, 1'b1);
		send_item(16'sd1024, 16'sd1024, 1'b1);
		send_item(-16'sd1024, 16'sd1024, 1'b1);
		send_item(16'sd64, 16'sd64, 1'b1);
		send_item(16'sd64, -16'sd64, 1'b1);
		drain_results();
	endtask

	// Long runs of maximum products push the sum far outside the window both ways.
	task automatic test_accumulator_large();
		int i;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		for (i = 0; i < LARGE_TERMS; i++) begin
			send_item(-16'sd32768, -16'sd32768, 1'b0);
		end
		send_item(16'sd1, 16'sd1, 1'b1);
		for (i = 0; i < LARGE_TERMS; i++) begin
			send_item(-16'sd32768, 16'sd32767, 1'b0);
		end
		send_item(16'sd1, 16'sd1, 1'b1);
		drain_results();
	endtask

	task automatic test_backpressure();
		int i;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_request = 150;
		for (i = 0; i < 48; i++) begin
			send_item(random_q412(1'b0), random_q412(1'b0), 1'b1);
		end
		drain_results();
	endtask

	task automatic test_random_neurons();
		int  sent;
		int  len;
		int  i;
		bit  wide;
		sent = 0;
		while (sent < 1100) begin
			if ((sent % 64) < 8) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			wide = ($urandom_range(0, 3) == 0);
			for (i = 0; i < len; i++) begin
				send_item(random_q412(wide), random_q412(wide), i == len - 1);
				sent++;
			end
		end
		drain_results();
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_neuron_values.size() == 0) begin
				$error("unexpected result: neuron_value %0d", neuron_value);
				errors++;
			end else begin
				wanted_value = expected_neuron_values.pop_front();
				if (neuron_value !== wanted_value) begin
					$error("neuron_value mismatch: expected %0d, actual %0d",
						wanted_value, neuron_value);
					errors++;
				end
			end
		end
	end

	initial begin
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request != 0) begin
				gap = hold_request;
				hold_request = 0;
			end else begin
				gap = recv_idle ? $urandom_range(0, 19) : 0;
			end
			repeat (gap) begin
				pop <= 1'b0;
				@(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	initial begin
		#16_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		activation = '0;
		weight = '0;
		last_term = 1'b0;
		errors = 0;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_request = 0;
		mac_sum = '0;
		build_sigmoid_lut();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_field_extremes();
		test_clamp_edges();
		test_accumulator_large();
		test_backpressure();
		test_random_neurons();
		if (expected_neuron_values.size() != 0) begin
			$error("%0d expected results never arrived", expected_neuron_values.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/dns_pkg.sv
rtl/core/dns_fifo.sv
rtl/core/dns_front.sv
rtl/core/dns_back.sv
rtl/core/dense_neuron_sigmoid_unit.sv
rtl/core/dns_checker.sv
tb/sv/tb_dense_neuron_sigmoid_unit.sv
